FILE: hdl/mam_pkg.sv
// Shared types, command codes and constants for the 3x3 matrix add/multiply block.
package mam_pkg;

	localparam int DIM_DEFAULT = 3;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = 2;

	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_B = 2'd1;
	localparam logic [1:0] CMD_ADD    = 2'd2;
	localparam logic [1:0] CMD_MUL    = 2'd3;

	typedef struct packed {
		logic [1:0]               command;
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic signed [DATA_W-1:0] element_value;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_row;
		logic [IDX_W-1:0]         out_col;
		logic signed [DATA_W-1:0] out_value;
		logic                     is_last;
	} out_item_t;

	typedef struct packed {
		logic capture;   // register sum or product of the operands
		logic mul_mode;  // product rather than sum
		logic accum;     // add held term into the accumulator
		logic first;     // start the accumulator from zero
	} alu_ctrl_t;

endpackage

FILE: hdl/mam_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/mam_alu.sv
// Shared arithmetic unit: one adder/multiplier stage followed by an accumulator.
module mam_alu
	import mam_pkg::*;
(
	input  logic              clk,
	input  alu_ctrl_t         ctrl,
	input  logic [DATA_W-1:0] a_data,
	input  logic [DATA_W-1:0] b_data,
	output logic [DATA_W-1:0] acc
);

	logic [DATA_W-1:0] term_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] prod;
	logic [DATA_W-1:0] sum;

	// low word of the product is all that survives the wrap
	assign prod = a_data * b_data;
	assign sum  = a_data + b_data;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			term_q <= ctrl.mul_mode ? prod : sum;
		end
		if (ctrl.accum) begin
			acc_q <= (ctrl.first ? '0 : acc_q) + term_q;
		end
	end

	assign acc = acc_q;

endmodule

FILE: hdl/mam_seq.sv
// Sequencer: takes commands, drives store writes and reads, steps the shared unit, holds the result.
module mam_seq
	import mam_pkg::*;
#(
	parameter int DIM = DIM_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  in_item_t                      in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output out_item_t                     out_item,
	output logic                          we_a,
	output logic                          we_b,
	output logic [$clog2(DIM*DIM)-1:0]    waddr,
	output logic [DATA_W-1:0]             wdata,
	output logic                          re,
	output logic [$clog2(DIM*DIM)-1:0]    raddr_a,
	output logic [$clog2(DIM*DIM)-1:0]    raddr_b,
	output alu_ctrl_t                     alu_ctrl,
	input  logic [DATA_W-1:0]             acc
);

	localparam int AW = $clog2(DIM*DIM);
	localparam int RW = $clog2(DIM);
	localparam logic [RW-1:0] LAST_IDX = RW'(DIM-1);
	localparam logic [3:0]    DIM_W4   = 4'(DIM);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_CAPT = 3'd2;
	localparam logic [2:0] S_ACC  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]    state_q;
	logic [RW-1:0] r_q;
	logic [RW-1:0] c_q;
	logic [RW-1:0] k_q;
	logic          mul_q;
	logic          out_valid_q;
	out_item_t     out_item_q;

	logic accept;
	logic is_load;
	logic in_range;
	logic last_cell;
	logic emit_go;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_load   = (in_item.command == CMD_LOAD_A) || (in_item.command == CMD_LOAD_B);
	assign in_range  = ({2'b00, in_item.row_index} < DIM_W4) &&
	                   ({2'b00, in_item.col_index} < DIM_W4);
	assign last_cell = (r_q == LAST_IDX) && (c_q == LAST_IDX);
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// store writes come straight from the accepted item
	assign we_a  = accept && (in_item.command == CMD_LOAD_A) && in_range;
	assign we_b  = accept && (in_item.command == CMD_LOAD_B) && in_range;
	assign waddr = AW'(AW'(in_item.row_index) * AW'(DIM) + AW'(in_item.col_index));
	assign wdata = in_item.element_value;

	// add reads A[r][c] and B[r][c]; multiply reads A[r][k] and B[k][c]
	assign re      = (state_q == S_READ);
	assign raddr_a = AW'(AW'(r_q) * AW'(DIM) + AW'(mul_q ? k_q : c_q));
	assign raddr_b = mul_q ? AW'(AW'(k_q) * AW'(DIM) + AW'(c_q))
	                       : AW'(AW'(r_q) * AW'(DIM) + AW'(c_q));

	always_comb begin
		alu_ctrl          = '0;
		alu_ctrl.capture  = (state_q == S_CAPT);
		alu_ctrl.mul_mode = mul_q;
		alu_ctrl.accum    = (state_q == S_ACC);
		alu_ctrl.first    = !mul_q || (k_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			mul_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && !is_load) begin
						mul_q   <= (in_item.command == CMD_MUL);
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CAPT;
				end
				S_CAPT: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (mul_q && (k_q != LAST_IDX)) begin
						k_q     <= k_q + RW'(1);
						state_q <= S_READ;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// hold until the output register is free
					if (emit_go) begin
						k_q <= '0;
						if (c_q == LAST_IDX) begin
							c_q <= '0;
							r_q <= r_q + RW'(1);
						end else begin
							c_q <= c_q + RW'(1);
						end
						state_q <= last_cell ? S_IDLE : S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_item_q.out_row   <= IDX_W'(r_q);
			out_item_q.out_col   <= IDX_W'(c_q);
			out_item_q.out_value <= acc;
			out_item_q.is_last   <= last_cell;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

FILE: hdl/matrix_add_multiply_3x3_top.sv
// Top level of the matrix add/multiply block: stores, cleared-entry tracking, unit and sequencer.
//
// Usage: items arrive on in_valid/in_ready/in_item, results leave on
// out_valid/out_ready/out_item; an item moves when valid and ready are high
// at a rising edge of clk.
// A load item (command load A or load B) writes one element; a load whose
// row or column is not below DIM is dropped. Loads produce no result.
// An add item yields DIM*DIM results in row-major order, each through
// store read, add, accumulate and emit. A multiply item yields DIM*DIM dot
// products in the same order; the single multiplier takes the terms one
// after another, each through store read, multiply and accumulate, before
// the dot product is emitted. The last result carries is_last.
// in_ready is low from acceptance of an add or multiply until its last
// result sits in the output register; the next item may enter then.
// A stalled receiver holds the sequencer at its current result; no result
// is lost. Reset (arst_n low) clears both matrices at once through per-entry
// valid flags and drops any pending result.
module matrix_add_multiply_3x3_top
	import mam_pkg::*;
#(
	parameter int DIM = DIM_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int CELLS = DIM * DIM;
	localparam int AW    = $clog2(CELLS);

	logic              we_a;
	logic              we_b;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr_a;
	logic [AW-1:0]     raddr_b;
	logic [DATA_W-1:0] ram_a;
	logic [DATA_W-1:0] ram_b;
	logic [DATA_W-1:0] a_data;
	logic [DATA_W-1:0] b_data;
	logic [DATA_W-1:0] acc;
	alu_ctrl_t         alu_ctrl;

	logic [CELLS-1:0]  va_q;
	logic [CELLS-1:0]  vb_q;
	logic              va_rd_q;
	logic              vb_rd_q;

	mam_seq #(.DIM(DIM)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.we_a      (we_a),
		.we_b      (we_b),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.alu_ctrl  (alu_ctrl),
		.acc       (acc)
	);

	mam_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr_a),
		.rdata (ram_a)
	);

	mam_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr_b),
		.rdata (ram_b)
	);

	// an entry never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q    <= '0;
			vb_q    <= '0;
			va_rd_q <= 1'b0;
			vb_rd_q <= 1'b0;
		end else begin
			if (we_a) begin
				va_q[waddr] <= 1'b1;
			end
			if (we_b) begin
				vb_q[waddr] <= 1'b1;
			end
			if (re) begin
				va_rd_q <= va_q[raddr_a];
				vb_rd_q <= vb_q[raddr_b];
			end
		end
	end

	assign a_data = va_rd_q ? ram_a : '0;
	assign b_data = vb_rd_q ? ram_b : '0;

	mam_alu u_alu (
		.clk    (clk),
		.ctrl   (alu_ctrl),
		.a_data (a_data),
		.b_data (b_data),
		.acc    (acc)
	);

`ifndef SYNTHESIS
	// a stalled result stays put until the receiver takes it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed or dropped");

	// an earlier result of a matrix never coexists with a ready input
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.is_last |-> !in_ready)
		else $error("input ready mid-matrix");

	// add and multiply items start a sequence that blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready &&
		(in_item.command == CMD_ADD || in_item.command == CMD_MUL) |=> !in_ready)
		else $error("compute item did not start the sequencer");
`endif

endmodule

FILE: verif/mam_checker.sv
// Checker for the matrix add/multiply block: tracks both matrices, predicts every result and compares.
module mam_checker
	import mam_pkg::*;
#(
	parameter int DIM = DIM_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_item,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_item,
	output int        mismatches,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [DATA_W-1:0] held_a [DIM*DIM];
	logic [DATA_W-1:0] held_b [DIM*DIM];
	out_item_t         due_cells [$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic logic [DATA_W-1:0] cell_value(logic [1:0] op, int r, int c);
		logic [DATA_W-1:0] acc;
		acc = '0;
		if (op == CMD_ADD)
			return held_a[r*DIM+c] + held_b[r*DIM+c];
		// keep only the low word of each term, as the hardware does
		for (int k = 0; k < DIM; k++)
			acc = acc + held_a[r*DIM+k] * held_b[k*DIM+c];
		return acc;
	endfunction

	task automatic take_command(in_item_t it);
		out_item_t res_item;
		int        idx;
		case (it.command)
			CMD_LOAD_A, CMD_LOAD_B: begin
				// drop loads that fall outside the matrix
				if (it.row_index < DIM && it.col_index < DIM) begin
					idx = it.row_index * DIM + it.col_index;
					if (it.command == CMD_LOAD_A)
						held_a[idx] = it.element_value;
					else
						held_b[idx] = it.element_value;
				end
			end
			CMD_ADD, CMD_MUL: begin
				for (int r = 0; r < DIM; r++) begin
					for (int c = 0; c < DIM; c++) begin
						res_item.out_row   = IDX_W'(r);
						res_item.out_col   = IDX_W'(c);
						res_item.out_value = cell_value(it.command, r, c);
						res_item.is_last   = (r == DIM - 1) && (c == DIM - 1);
						due_cells.insert(due_cells.size(), res_item);
					end
				end
			end
		endcase
	endtask

	task automatic check_cell(out_item_t got);
		out_item_t want;
		if (due_cells.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: result row %0d col %0d value %0d last %0b with nothing expected",
					$realtime, got.out_row, got.out_col, got.out_value, got.is_last);
			mismatches++;
			return;
		end
		want = due_cells.pop_front();
		if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
		    got.out_value !== want.out_value || got.is_last !== want.is_last) begin
			if (mismatches < 10)
				$display("%0t: expected row %0d col %0d value %0d last %0b,",
					$realtime, want.out_row, want.out_col, want.out_value, want.is_last,
					" got row %0d col %0d value %0d last %0b",
					got.out_row, got.out_col, got.out_value, got.is_last);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM*DIM; i++) begin
				held_a[i] = '0;
				held_b[i] = '0;
			end
			due_cells.delete();
		end else begin
			if (out_valid && out_ready)
				check_cell(out_item);
			if (in_valid && in_ready)
				take_command(in_item);
		end
		pending = due_cells.size();
	end

endmodule

FILE: verif/testbench.sv
// Top of the matrix add/multiply testbench: clock, reset, item stimulus, receiver stalls and verdict.
module testbench
	import mam_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM = DIM_DEFAULT;
	localparam int RANDOM_ITEMS = 480;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	int        mismatches;
	int        pending;
	int        sent = 0;

	always #10 clk = ~clk;

	matrix_add_multiply_3x3_top #(.DIM(DIM)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	mam_checker #(.DIM(DIM)) check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.mismatches(mismatches),
		.pending   (pending)
	);

	function automatic int unsigned idle_span();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [DATA_W-1:0] operand();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hFFFF_FFFF;
					3: return 32'h7FFF_FFFF;
					default: return 32'h8000_0000;
				endcase
			end
			1, 2: return $urandom_range(0, 16) - 8;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t    it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 38)
			it.command = CMD_LOAD_A;
		else if (pick < 76)
			it.command = CMD_LOAD_B;
		else if (pick < 88)
			it.command = CMD_ADD;
		else
			it.command = CMD_MUL;
		if (it.command == CMD_LOAD_A || it.command == CMD_LOAD_B) begin
			// mostly in range, now and then a load that must be dropped
			it.row_index = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 3))
			                                           : IDX_W'($urandom_range(0, DIM-1));
			it.col_index = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 3))
			                                           : IDX_W'($urandom_range(0, DIM-1));
		end else begin
			it.row_index = IDX_W'($urandom_range(0, 3));
			it.col_index = IDX_W'($urandom_range(0, 3));
		end
		it.element_value = operand();
		return it;
	endfunction

	// hold valid and the item until accepted; idle first for a random gap
	task automatic send(in_item_t it);
		int unsigned gap;
		logic [63:0] noise;
		gap = (sent % 64 < 16) ? 0 : idle_span();
		if (gap > 0) begin
			noise = {$urandom, $urandom};
			@(negedge clk);
			in_valid <= 1'b0;
			in_item  <= noise[$bits(in_item_t)-1:0];
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic issue(logic [1:0] op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
	                     logic [DATA_W-1:0] v);
		in_item_t it;
		it.command       = op;
		it.row_index     = r;
		it.col_index     = c;
		it.element_value = v;
		send(it);
	endtask

	initial begin
		#20_000_000;
		$display("matrix_add_multiply_3x3_top verification failed");
		$finish;
	end

	// receiver: ready bursts broken by stalls, with long steady stretches
	initial begin
		int unsigned hold;
		int unsigned gap;
		int          round;
		round = 0;
		@(posedge arst_n);
		forever begin
			hold = (round % 20 < 4) ? 60 : $urandom_range(1, 6);
			@(negedge clk);
			out_ready <= 1'b1;
			repeat (hold - 1) @(negedge clk);
			gap = (round % 20 < 4) ? 0 : idle_span();
			if (gap > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			round++;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// both matrices are zero straight after reset
		issue(CMD_MUL, 2'd0, 2'd0, 32'h0);
		issue(CMD_ADD, 2'd0, 2'd0, 32'h0);

		issue(CMD_LOAD_A, 2'd0, 2'd0, 32'h7FFF_FFFF);
		issue(CMD_LOAD_A, 2'd0, 2'd1, 32'h8000_0000);
		issue(CMD_LOAD_A, 2'd0, 2'd2, 32'hFFFF_FFFF);
		issue(CMD_LOAD_A, 2'd1, 2'd0, 32'h0000_0001);
		issue(CMD_LOAD_A, 2'd1, 2'd2, 32'h5555_5555);
		issue(CMD_LOAD_A, 2'd2, 2'd2, 32'h7FFF_FFFF);
		issue(CMD_LOAD_B, 2'd0, 2'd0, 32'h7FFF_FFFF);
		issue(CMD_LOAD_B, 2'd1, 2'd0, 32'h8000_0000);
		issue(CMD_LOAD_B, 2'd2, 2'd0, 32'hFFFF_FFFF);
		issue(CMD_LOAD_B, 2'd1, 2'd1, 32'h0000_0002);
		issue(CMD_LOAD_B, 2'd2, 2'd1, 32'hAAAA_AAAA);
		issue(CMD_LOAD_B, 2'd2, 2'd2, 32'hFFFF_FFFF);

		// out-of-range loads leave both matrices untouched
		issue(CMD_LOAD_A, 2'd3, 2'd0, 32'hDEAD_BEEF);
		issue(CMD_LOAD_B, 2'd0, 2'd3, 32'hDEAD_BEEF);
		issue(CMD_LOAD_A, 2'd3, 2'd3, 32'hFFFF_FFFF);
		issue(CMD_LOAD_B, 2'd3, 2'd3, 32'h8000_0000);

		// index and value fields are ignored by the compute commands
		issue(CMD_ADD, 2'd3, 2'd3, 32'hFFFF_FFFF);
		issue(CMD_MUL, 2'd3, 2'd3, 32'h8000_0000);
		issue(CMD_MUL, 2'd1, 2'd2, 32'h1234_5678);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			send(random_item());
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("matrix_add_multiply_3x3_top verification clean");
		else
			$display("matrix_add_multiply_3x3_top verification failed");
		$finish;
	end

endmodule

FILE: matrix_add_multiply_3x3_top.f
hdl/mam_pkg.sv
hdl/mam_ram.sv
hdl/mam_alu.sv
hdl/mam_seq.sv
hdl/matrix_add_multiply_3x3_top.sv
verif/mam_checker.sv
verif/testbench.sv
